[design/pnd_pkg.sv]
// ----------------------------------------------------------------------------
// pnd_pkg: shared types and constants of the path neighbor distance core
// Field widths, command and register codes, the command control group
// that travels from the front end to the back end, and back end states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pnd_pkg;

   localparam int FUNC_W      = 2;
   localparam int POS_W       = 10;
   localparam int COORD_IN_W  = 16;
   localparam int LEN_W       = 11;
   localparam int TOTAL_W     = 18;
   localparam int COUNT_W     = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;

   localparam logic [LEN_W-1:0]   LEN_RESET = 11'd1;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = 18'h3FFFF;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_WRITE         = 2'd0,
      FUNC_BOTH_STORED   = 2'd1,
      FUNC_BOTH_SUPPLIED = 2'd2,
      FUNC_LEFT_SUPPLIED = 2'd3
   } func_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CLOSED_PATH = 2'd0,
      CSR_MEASURE     = 2'd1,
      CSR_PATH_LENGTH = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic is_write;
      logic bad;
      logic has_left;
      logic has_right;
      logic ref_stored;
   } cmd_ctl_type;

   localparam int CMD_CTL_W = $bits(cmd_ctl_type);

   typedef enum logic [3:0] {
      B_IDLE,
      B_WMOD,
      B_WFIX,
      B_WRITE,
      B_RREF,
      B_LREF,
      B_START,
      B_RNB,
      B_DIFF,
      B_SQR,
      B_SUM,
      B_ROOT,
      B_ACC,
      B_OUT
   } back_state_type;

endpackage

`default_nettype wire

[design/pnd_ifs.sv]
// ----------------------------------------------------------------------------
// pnd_ifs: channel interfaces of the path neighbor distance core
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pnd_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [pnd_pkg::FUNC_W-1:0]           func;
   logic [pnd_pkg::POS_W-1:0]            position;
   logic signed [pnd_pkg::COORD_IN_W-1:0] point_x;
   logic signed [pnd_pkg::COORD_IN_W-1:0] point_y;

   modport source (output valid, func, position, point_x, point_y, input ready);
   modport sink (input valid, func, position, point_x, point_y, output ready);
endinterface

interface pnd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pnd_pkg::TOTAL_W-1:0]   total_distance;
   logic [pnd_pkg::COUNT_W-1:0]   neighbor_count;
   logic                          bad_position;

   modport source (output valid, total_distance, neighbor_count, bad_position,
                   input ready);
   modport sink (input valid, total_distance, neighbor_count, bad_position,
                 output ready);
endinterface

interface pnd_csr_if;
   logic                              valid;
   logic                              ready;
   logic [pnd_pkg::CSR_INDEX_W-1:0]   index;
   logic [pnd_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/pnd_front.sv]
// ----------------------------------------------------------------------------
// pnd_front: request front end
// Accepts request transactions while the command queue has room and
// classifies them: write or query, bad position, which neighbors exist and
// their table indices, and where the reference point comes from.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pnd_front #(
   parameter int MAX_POINTS  = 1024,
   parameter int COORD_WIDTH = 16
) (
   pnd_req_if.sink                      req,
   input  wire logic                    closed_path,
   input  wire logic [pnd_pkg::LEN_W-1:0] path_length,
   input  wire logic                    queue_full,
   output logic                         push,
   output pnd_pkg::cmd_ctl_type         ctl,
   output logic [pnd_pkg::POS_W-1:0]    pos,
   output logic [$clog2(MAX_POINTS)-1:0] left_idx,
   output logic [$clog2(MAX_POINTS)-1:0] right_idx,
   output logic [COORD_WIDTH-1:0]       x,
   output logic [COORD_WIDTH-1:0]       y
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int NW = $clog2(MAX_POINTS + 1);
   localparam int WW = (NW > pnd_pkg::LEN_W) ? NW : pnd_pkg::LEN_W;

   pnd_pkg::func_type func;
   logic [WW-1:0]     pos_w;
   logic [WW-1:0]     len_w;
   logic [WW-1:0]     n_w;
   logic [WW-1:0]     pos_next;
   logic              at_start;
   logic              right_inside;

   assign req.ready = !queue_full;
   assign push      = req.valid && !queue_full;

   assign func     = pnd_pkg::func_type'(req.func);
   assign pos_w    = WW'(req.position);
   assign len_w    = WW'(path_length);
   assign n_w      = (len_w > WW'(MAX_POINTS)) ? WW'(MAX_POINTS) : len_w;
   assign pos_next = pos_w + WW'(1);
   assign at_start = (req.position == '0);
   assign right_inside = (pos_next < n_w);

   always_comb begin
      ctl.is_write   = (func == pnd_pkg::FUNC_WRITE);
      ctl.bad        = (pos_w >= n_w);
      ctl.ref_stored = (func == pnd_pkg::FUNC_BOTH_STORED);
      ctl.has_left   = !at_start || closed_path;
      ctl.has_right  = (func != pnd_pkg::FUNC_LEFT_SUPPLIED) && (right_inside || closed_path);
   end

   // Neighbors wrap to the far end of the ring; the open-path case is
   // filtered out by the has_left and has_right flags.
   assign left_idx  = at_start ? AW'(n_w - WW'(1)) : AW'(pos_w - WW'(1));
   assign right_idx = right_inside ? AW'(pos_next) : '0;
   assign pos       = req.position;

   // Unsigned resize: low bits are kept, wider coordinates are zero filled.
   assign x = COORD_WIDTH'($unsigned(req.point_x));
   assign y = COORD_WIDTH'($unsigned(req.point_y));

endmodule

`default_nettype wire

[design/pnd_queue.sv]
// ----------------------------------------------------------------------------
// pnd_queue: command queue
// Two-entry first-in first-out buffer between the front end and the
// back end, so that each side can stall independently.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pnd_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  head_valid,
   output logic [WIDTH-1:0]      head_data
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   logic             do_push;
   logic             do_pop;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[design/pnd_back.sv]
// ----------------------------------------------------------------------------
// pnd_back: command back end
// Owns the point table. Executes writes, and for queries reads the
// reference and neighbor points, forms Manhattan or Euclidean distances with
// a shared bit-per-cycle square root, sums them and drives the response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pnd_back #(
   parameter int MAX_POINTS  = 1024,
   parameter int COORD_WIDTH = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        measure,
   input  wire logic                        cmd_valid,
   input  wire pnd_pkg::cmd_ctl_type        cmd_ctl,
   input  wire logic [pnd_pkg::POS_W-1:0]   cmd_pos,
   input  wire logic [$clog2(MAX_POINTS)-1:0] cmd_left,
   input  wire logic [$clog2(MAX_POINTS)-1:0] cmd_right,
   input  wire logic [COORD_WIDTH-1:0]      cmd_x,
   input  wire logic [COORD_WIDTH-1:0]      cmd_y,
   output logic                             cmd_pop,
   pnd_rsp_if.source                        rsp
);

   localparam int AW    = $clog2(MAX_POINTS);
   localparam int CW    = COORD_WIDTH;
   localparam int SW    = 2 * CW + 1;
   localparam int DW    = CW + 1;
   localparam int TW    = (CW + 2 > pnd_pkg::TOTAL_W) ? CW + 2 : pnd_pkg::TOTAL_W;
   localparam int TOPB  = 2 * CW;
   localparam int RSH   = 20;
   localparam int RECIP = (1 << RSH) / MAX_POINTS;

   function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a,
                                              input logic [CW-1:0] b);
      logic signed [CW:0] d;
      d = (CW+1)'($signed(a)) - (CW+1)'($signed(b));
      return (d < 0) ? CW'(-d) : CW'(d);
   endfunction

   // Point table: x in the upper half, y in the lower half of each word.
   logic [2*CW-1:0] mem [MAX_POINTS];
   logic [2*CW-1:0] mem_rd_ff;
   logic            mem_we;
   logic [AW-1:0]   mem_wa;
   logic [AW-1:0]   mem_ra;

   pnd_pkg::back_state_type state_ff, state_in;
   pnd_pkg::cmd_ctl_type    ctl_ff, ctl_in;
   logic [pnd_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic [pnd_pkg::POS_W-1:0]     quot_ff, quot_in;
   logic [AW-1:0]                 left_ff, left_in;
   logic [AW-1:0]                 right_ff, right_in;
   logic [CW-1:0]                 rx_ff, rx_in;
   logic [CW-1:0]                 ry_ff, ry_in;
   logic                          sel_ff, sel_in;
   logic [CW-1:0]                 dx_ff, dx_in;
   logic [CW-1:0]                 dy_ff, dy_in;
   logic [2*CW-1:0]               sqx_ff, sqx_in;
   logic [2*CW-1:0]               sqy_ff, sqy_in;
   logic [SW-1:0]                 v_ff, v_in;
   logic [SW-1:0]                 res_ff, res_in;
   logic [SW-1:0]                 bit_ff, bit_in;
   logic [DW-1:0]                 dist_ff, dist_in;
   logic [TW-1:0]                 acc_ff, acc_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [pnd_pkg::TOTAL_W-1:0]   rsp_total_ff, rsp_total_in;
   logic [pnd_pkg::COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                          rsp_bad_ff, rsp_bad_in;

   logic [31:0]   quot_wide;
   logic [31:0]   rem_wide;
   logic [SW-1:0] root_trial;
   logic          root_ge;
   logic [SW-1:0] root_next;

   // The reciprocal quotient of the write index is exact or one short.
   assign quot_wide  = (32'(pos_ff) * 32'(RECIP)) >> RSH;
   assign rem_wide   = 32'(pos_ff) - 32'(quot_ff) * 32'(MAX_POINTS);
   assign root_trial = res_ff + bit_ff;
   assign root_ge    = (v_ff >= root_trial);
   assign root_next  = root_ge ? (res_ff >> 1) + bit_ff : res_ff >> 1;

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.total_distance = rsp_total_ff;
   assign rsp.neighbor_count = rsp_count_ff;
   assign rsp.bad_position   = rsp_bad_ff;

   always_comb begin
      state_in     = state_ff;
      ctl_in       = ctl_ff;
      pos_in       = pos_ff;
      quot_in      = quot_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      sel_in       = sel_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      sqx_in       = sqx_ff;
      sqy_in       = sqy_ff;
      v_in         = v_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      dist_in      = dist_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_total_in = rsp_total_ff;
      rsp_count_in = rsp_count_ff;
      rsp_bad_in   = rsp_bad_ff;
      cmd_pop      = 1'b0;
      mem_we       = 1'b0;
      mem_wa       = AW'(pos_ff);
      mem_ra       = sel_ff ? right_ff : left_ff;

      case (state_ff)
         pnd_pkg::B_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               ctl_in   = cmd_ctl;
               pos_in   = cmd_pos;
               left_in  = cmd_left;
               right_in = cmd_right;
               rx_in    = cmd_x;
               ry_in    = cmd_y;
               sel_in   = 1'b0;
               acc_in   = '0;
               if (cmd_ctl.is_write) begin
                  state_in = pnd_pkg::B_WMOD;
               end else if (cmd_ctl.bad) begin
                  state_in = pnd_pkg::B_OUT;
               end else if (cmd_ctl.ref_stored) begin
                  state_in = pnd_pkg::B_RREF;
               end else begin
                  state_in = pnd_pkg::B_START;
               end
            end
         end
         pnd_pkg::B_WMOD: begin
            quot_in  = pnd_pkg::POS_W'(quot_wide);
            state_in = pnd_pkg::B_WFIX;
         end
         pnd_pkg::B_WFIX: begin
            // One compare and subtract covers a quotient that came out short.
            if (rem_wide >= 32'(MAX_POINTS)) begin
               pos_in = pnd_pkg::POS_W'(rem_wide - 32'(MAX_POINTS));
            end else begin
               pos_in = pnd_pkg::POS_W'(rem_wide);
            end
            state_in = pnd_pkg::B_WRITE;
         end
         pnd_pkg::B_WRITE: begin
            mem_we   = 1'b1;
            state_in = pnd_pkg::B_IDLE;
         end
         pnd_pkg::B_RREF: begin
            mem_ra   = AW'(pos_ff);
            state_in = pnd_pkg::B_LREF;
         end
         pnd_pkg::B_LREF: begin
            rx_in    = mem_rd_ff[2*CW-1:CW];
            ry_in    = mem_rd_ff[CW-1:0];
            state_in = pnd_pkg::B_START;
         end
         pnd_pkg::B_START: begin
            if (ctl_ff.has_left) begin
               sel_in   = 1'b0;
               state_in = pnd_pkg::B_RNB;
            end else if (ctl_ff.has_right) begin
               sel_in   = 1'b1;
               state_in = pnd_pkg::B_RNB;
            end else begin
               state_in = pnd_pkg::B_OUT;
            end
         end
         pnd_pkg::B_RNB: begin
            state_in = pnd_pkg::B_DIFF;
         end
         pnd_pkg::B_DIFF: begin
            dx_in    = abs_diff(mem_rd_ff[2*CW-1:CW], rx_ff);
            dy_in    = abs_diff(mem_rd_ff[CW-1:0], ry_ff);
            state_in = pnd_pkg::B_SQR;
         end
         pnd_pkg::B_SQR: begin
            if (measure) begin
               sqx_in   = dx_ff * dx_ff;
               sqy_in   = dy_ff * dy_ff;
               state_in = pnd_pkg::B_SUM;
            end else begin
               dist_in  = DW'(dx_ff) + DW'(dy_ff);
               state_in = pnd_pkg::B_ACC;
            end
         end
         pnd_pkg::B_SUM: begin
            v_in     = SW'(sqx_ff) + SW'(sqy_ff);
            res_in   = '0;
            bit_in   = SW'(1) << TOPB;
            state_in = pnd_pkg::B_ROOT;
         end
         pnd_pkg::B_ROOT: begin
            // One result bit per cycle; the trial bit walks down two places.
            if (root_ge) begin
               v_in = v_ff - root_trial;
            end
            res_in = root_next;
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               dist_in  = DW'(root_next);
               state_in = pnd_pkg::B_ACC;
            end
         end
         pnd_pkg::B_ACC: begin
            acc_in = acc_ff + TW'(dist_ff);
            if (!sel_ff && ctl_ff.has_right) begin
               sel_in   = 1'b1;
               state_in = pnd_pkg::B_RNB;
            end else begin
               state_in = pnd_pkg::B_OUT;
            end
         end
         pnd_pkg::B_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_total_in = (acc_ff > TW'(pnd_pkg::TOTAL_MAX)) ?
                              pnd_pkg::TOTAL_MAX : pnd_pkg::TOTAL_W'(acc_ff);
               rsp_count_in = ctl_ff.bad ? '0 :
                              pnd_pkg::COUNT_W'(ctl_ff.has_left) +
                              pnd_pkg::COUNT_W'(ctl_ff.has_right);
               rsp_bad_in   = ctl_ff.bad;
               state_in     = pnd_pkg::B_IDLE;
            end
         end
         default: begin
            state_in = pnd_pkg::B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pnd_pkg::B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ctl_ff       <= ctl_in;
      pos_ff       <= pos_in;
      quot_ff      <= quot_in;
      left_ff      <= left_in;
      right_ff     <= right_in;
      rx_ff        <= rx_in;
      ry_ff        <= ry_in;
      sel_ff       <= sel_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      sqx_ff       <= sqx_in;
      sqy_ff       <= sqy_in;
      v_ff         <= v_in;
      res_ff       <= res_in;
      bit_ff       <= bit_in;
      dist_ff      <= dist_in;
      acc_ff       <= acc_in;
      rsp_total_ff <= rsp_total_in;
      rsp_count_ff <= rsp_count_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= {rx_ff, ry_ff};
      end
      mem_rd_ff <= mem[mem_ra];
   end

endmodule

`default_nettype wire

[design/path_neighbor_distance_core.sv]
// ----------------------------------------------------------------------------
// path_neighbor_distance_core: path neighbor distance unit
// Point table with neighbor distance queries, Manhattan or Euclidean.
// ----------------------------------------------------------------------------
// Usage:
// Request transactions on req_chan either store a point (func write) or ask
// for the summed distance from the neighbors of a position to a reference
// point. Each query returns one response transaction on rsp_chan; writes
// return none. Registers (closed path, measure, path length) are written on
// csr_chan; the user must write them only while the core is idle, which the
// core itself does not enforce; csr_chan is always ready. Requests pass
// through a two-entry command queue, so up to two requests are taken while
// the back end is busy. The back end handles one command at a time. A write
// passes through pop, quotient, remainder and table write steps. A query
// reads the stored reference point first when there is one, then each
// neighbor; with Euclidean distance each neighbor also passes through the
// iterative square root, one result bit per cycle. An out-of-range position
// is answered without reading the table.
// Reset clears the queue, the response register and the registers (closed
// path 0, Manhattan, length 1); the point table is not cleared. A stalled
// receiver holds the response; the back end waits, then the queue fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module path_neighbor_distance_core #(
   parameter int MAX_POINTS  = 1024,
   parameter int COORD_WIDTH = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   pnd_req_if.sink   req_chan,
   pnd_rsp_if.source rsp_chan,
   pnd_csr_if.sink   csr_chan
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int QW = pnd_pkg::CMD_CTL_W + pnd_pkg::POS_W + 2 * AW + 2 * COORD_WIDTH;

   logic                        closed_ff, closed_in;
   logic                        measure_ff, measure_in;
   logic [pnd_pkg::LEN_W-1:0]   length_ff, length_in;
   logic                        csr_write;

   logic                        push;
   logic                        queue_full;
   pnd_pkg::cmd_ctl_type        front_ctl;
   logic [pnd_pkg::POS_W-1:0]   front_pos;
   logic [AW-1:0]               front_left;
   logic [AW-1:0]               front_right;
   logic [COORD_WIDTH-1:0]      front_x;
   logic [COORD_WIDTH-1:0]      front_y;
   logic [QW-1:0]               push_data;

   logic                        head_valid;
   logic [QW-1:0]               head_data;
   logic                        pop;
   pnd_pkg::cmd_ctl_type        head_ctl;
   logic [pnd_pkg::POS_W-1:0]   head_pos;
   logic [AW-1:0]               head_left;
   logic [AW-1:0]               head_right;
   logic [COORD_WIDTH-1:0]      head_x;
   logic [COORD_WIDTH-1:0]      head_y;

   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid;

   always_comb begin
      closed_in  = closed_ff;
      measure_in = measure_ff;
      length_in  = length_ff;
      if (csr_write) begin
         case (pnd_pkg::csr_index_type'(csr_chan.index))
            pnd_pkg::CSR_CLOSED_PATH: closed_in  = csr_chan.data[0];
            pnd_pkg::CSR_MEASURE:     measure_in = csr_chan.data[0];
            pnd_pkg::CSR_PATH_LENGTH: length_in  = pnd_pkg::LEN_W'(csr_chan.data);
            default: begin
               closed_in = closed_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         closed_ff  <= 1'b0;
         measure_ff <= 1'b0;
         length_ff  <= pnd_pkg::LEN_RESET;
      end else begin
         closed_ff  <= closed_in;
         measure_ff <= measure_in;
         length_ff  <= length_in;
      end
   end

   pnd_front #(
      .MAX_POINTS  (MAX_POINTS),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .req         (req_chan),
      .closed_path (closed_ff),
      .path_length (length_ff),
      .queue_full  (queue_full),
      .push        (push),
      .ctl         (front_ctl),
      .pos         (front_pos),
      .left_idx    (front_left),
      .right_idx   (front_right),
      .x           (front_x),
      .y           (front_y)
   );

   assign push_data = {front_ctl, front_pos, front_left, front_right, front_x, front_y};

   pnd_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   assign {head_ctl, head_pos, head_left, head_right, head_x, head_y} = head_data;

   pnd_back #(
      .MAX_POINTS  (MAX_POINTS),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .measure   (measure_ff),
      .cmd_valid (head_valid),
      .cmd_ctl   (head_ctl),
      .cmd_pos   (head_pos),
      .cmd_left  (head_left),
      .cmd_right (head_right),
      .cmd_x     (head_x),
      .cmd_y     (head_y),
      .cmd_pop   (pop),
      .rsp       (rsp_chan)
   );

endmodule

`default_nettype wire
